FILE: sv/psd_pkg.sv
package psd_pkg;

    // Request kinds carried on the opcode input.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    localparam logic [7:0] PREFIX_BYTE = 8'hE0;
    localparam int unsigned RELEASE_BIT = 7;
    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] CASE_GAP   = 7'd32;
    localparam logic [6:0] LOWER_A    = 7'h61;
    localparam logic [6:0] LOWER_Z    = 7'h7A;
    localparam logic [6:0] UPPER_A    = 7'h41;
    localparam logic [6:0] UPPER_Z    = 7'h5A;

    // One decoded keyboard event as stored in the event queue.
    typedef struct packed {
        logic       extended_prefix;
        logic       alt_held;
        logic       ctrl_held;
        logic       shift_held;
        logic       is_press;
        logic [6:0] char_code;
        logic [6:0] key_code;
    } event_t;

    // Command passed from the decoder to the queue engine.
    typedef struct packed {
        logic   is_pop;
        event_t evt;
    } cmd_t;

    // Unshifted translation; codes without a character give zero.
    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'd2:  c = 7'h31;
            7'd3:  c = 7'h32;
            7'd4:  c = 7'h33;
            7'd5:  c = 7'h34;
            7'd6:  c = 7'h35;
            7'd7:  c = 7'h36;
            7'd8:  c = 7'h37;
            7'd9:  c = 7'h38;
            7'd10: c = 7'h39;
            7'd11: c = 7'h30;
            7'd12: c = 7'h2D;
            7'd13: c = 7'h3D;
            7'd14: c = 7'h08;
            7'd15: c = 7'h09;
            7'd16: c = 7'h71;
            7'd17: c = 7'h77;
            7'd18: c = 7'h65;
            7'd19: c = 7'h72;
            7'd20: c = 7'h74;
            7'd21: c = 7'h79;
            7'd22: c = 7'h75;
            7'd23: c = 7'h69;
            7'd24: c = 7'h6F;
            7'd25: c = 7'h70;
            7'd26: c = 7'h5B;
            7'd27: c = 7'h5D;
            7'd28: c = 7'h0A;
            7'd30: c = 7'h61;
            7'd31: c = 7'h73;
            7'd32: c = 7'h64;
            7'd33: c = 7'h66;
            7'd34: c = 7'h67;
            7'd35: c = 7'h68;
            7'd36: c = 7'h6A;
            7'd37: c = 7'h6B;
            7'd38: c = 7'h6C;
            7'd39: c = 7'h3B;
            7'd40: c = 7'h27;
            7'd41: c = 7'h60;
            7'd43: c = 7'h5C;
            7'd44: c = 7'h7A;
            7'd45: c = 7'h78;
            7'd46: c = 7'h63;
            7'd47: c = 7'h76;
            7'd48: c = 7'h62;
            7'd49: c = 7'h6E;
            7'd50: c = 7'h6D;
            7'd51: c = 7'h2C;
            7'd52: c = 7'h2E;
            7'd53: c = 7'h2F;
            7'd55: c = 7'h2A;
            7'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Shifted translation. Letters fall through to the unshifted table,
    // since their case is settled afterwards from shift and caps lock.
    function automatic logic [6:0] shift_char(input logic [6:0] code);
        logic [6:0] c;
        case (code)
            7'd2:  c = 7'h21;
            7'd3:  c = 7'h40;
            7'd4:  c = 7'h23;
            7'd5:  c = 7'h24;
            7'd6:  c = 7'h25;
            7'd7:  c = 7'h5E;
            7'd8:  c = 7'h26;
            7'd9:  c = 7'h2A;
            7'd10: c = 7'h28;
            7'd11: c = 7'h29;
            7'd12: c = 7'h5F;
            7'd13: c = 7'h2B;
            7'd26: c = 7'h7B;
            7'd27: c = 7'h7D;
            7'd39: c = 7'h3A;
            7'd40: c = 7'h22;
            7'd41: c = 7'h7E;
            7'd43: c = 7'h7C;
            7'd51: c = 7'h3C;
            7'd52: c = 7'h3E;
            7'd53: c = 7'h3F;
            default: c = plain_char(code);
        endcase
        return c;
    endfunction

    // Full translation with caps lock applied to letters.
    function automatic logic [6:0] to_char(input logic [6:0] code, input logic shift,
                                           input logic caps);
        logic [6:0] c;
        logic       upper;
        upper = shift ^ caps;
        c = shift ? shift_char(code) : plain_char(code);
        if (c >= LOWER_A && c <= LOWER_Z) begin
            if (upper) begin
                c = c - CASE_GAP;
            end
        end else if (c >= UPPER_A && c <= UPPER_Z) begin
            if (!upper) begin
                c = c + CASE_GAP;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/ps2_scancode_decoder_event_fifo_unit.sv
// Set-1 scancode decoder with an event queue. Pulse start with opcode 0 to hand in a
// keyboard byte, or with opcode 1 to request the oldest event. A request is taken in
// any cycle where busy is low, one per cycle; busy goes high only if the two-entry
// command queue between the decoder and the queue engine fills, which the engine
// prevents by retiring one command every cycle. A pop answers on done, a one-cycle
// strobe; the request passes through the command queue register and then the done and
// read-data registers. The receiver cannot stall: sample the result on the strobe.
// event_valid low means the queue was empty and every field is zero. The queue keeps
// at most QUEUE_DEPTH-1 events and new events are dropped without notice when full;
// modifier state is still tracked for dropped events. Byte requests give no result.
module ps2_scancode_decoder_event_fifo_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    output logic       done,
    output logic       event_valid,
    output logic [6:0] key_code,
    output logic [6:0] char_code,
    output logic       is_press,
    output logic       shift_held,
    output logic       ctrl_held,
    output logic       alt_held,
    output logic       extended_prefix
);
    import psd_pkg::*;

    logic   accept;
    logic   push;
    cmd_t   push_cmd;
    logic   q_not_empty;
    logic   q_full;
    cmd_t   q_head;
    event_t evt;

    assign busy   = q_full;
    assign accept = start && !busy;

    // Decoder: classifies requests and builds events.
    psd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .opcode  (opcode),
        .rx_byte (rx_byte),
        .push    (push),
        .cmd     (push_cmd)
    );

    // Short command queue between the decoder and the queue engine.
    psd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_not_empty),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    // Queue engine: event memory and pop results.
    psd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_not_empty),
        .cmd         (q_head),
        .done        (done),
        .event_valid (event_valid),
        .evt         (evt)
    );

    assign key_code        = evt.key_code;
    assign char_code       = evt.char_code;
    assign is_press        = evt.is_press;
    assign shift_held      = evt.shift_held;
    assign ctrl_held       = evt.ctrl_held;
    assign alt_held        = evt.alt_held;
    assign extended_prefix = evt.extended_prefix;

`ifndef SYNTHESIS
    // Every pop request is answered on done after the command queue and done registers.
    a_pop_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_POP) |=> ##1 done)
        else $error("pop request not answered on time");

    // No result appears without an earlier pop request.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && opcode == OP_POP, 2))
        else $error("result without a pop request");

    // The engine retires one command per cycle, so the command queue never fills.
    a_queue_never_full: assert property (@(posedge clk) disable iff (!rst_n)
        !q_full)
        else $error("command queue filled up");
`endif

endmodule

FILE: sv/psd_front.sv
module psd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          opcode,
    input  logic [7:0]    rx_byte,
    output logic          push,
    output psd_pkg::cmd_t cmd
);
    import psd_pkg::*;

    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic caps_reg, caps_next;
    logic prefix_reg, prefix_next;
    logic       press;
    logic [6:0] code;

    assign press = ~rx_byte[RELEASE_BIT];
    assign code  = rx_byte[6:0];

    // Classify the request, update the modifier state and build the event.
    always_comb begin
        shift_next  = shift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        push        = 1'b0;
        cmd         = '0;
        if (accept) begin
            if (opcode == OP_POP) begin
                push       = 1'b1;
                cmd.is_pop = 1'b1;
            end else if (rx_byte == PREFIX_BYTE) begin
                prefix_next = 1'b1;
            end else begin
                if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
                    shift_next = press;
                end else if (code == KEY_CTRL) begin
                    ctrl_next = press;
                end else if (code == KEY_ALT) begin
                    alt_next = press;
                end else if (code == KEY_CAPS && press) begin
                    caps_next = ~caps_reg;
                end
                push                    = 1'b1;
                cmd.evt.key_code        = code;
                cmd.evt.char_code       = press ? to_char(code, shift_next, caps_next) : 7'd0;
                cmd.evt.is_press        = press;
                cmd.evt.shift_held      = shift_next;
                cmd.evt.ctrl_held       = ctrl_next;
                cmd.evt.alt_held        = alt_next;
                cmd.evt.extended_prefix = prefix_reg;
                prefix_next             = 1'b0;
            end
        end
    end

    // Modifier and prefix state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shift_reg  <= 1'b0;
            ctrl_reg   <= 1'b0;
            alt_reg    <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end else begin
            shift_reg  <= shift_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

FILE: sv/psd_cmd_queue.sv
module psd_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          not_empty,
    output logic          full,
    output psd_pkg::cmd_t head
);
    import psd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_idx_reg, wr_idx_next;
    logic       rd_idx_reg, rd_idx_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = entry_reg[rd_idx_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and occupancy update.
    always_comb begin
        wr_idx_next = do_push ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = do_pop ? ~rd_idx_reg : rd_idx_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_idx_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/psd_back.sv
module psd_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  psd_pkg::cmd_t   cmd,
    output logic            done,
    output logic            event_valid,
    output psd_pkg::event_t evt
);
    import psd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    event_t           event_store_reg [QUEUE_DEPTH];
    event_t           rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             done_reg, done_next;
    logic             hit_reg, hit_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic             empty;
    logic             full;
    logic             do_write;

    assign wr_ptr_inc = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);
    assign do_write   = cmd_valid && !cmd.is_pop && !full;

    // Carry out one command: store an event (dropped when full) or pop one.
    always_comb begin
        wr_ptr_next = do_write ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        done_next   = 1'b0;
        hit_next    = 1'b0;
        if (cmd_valid && cmd.is_pop) begin
            done_next = 1'b1;
            if (!empty) begin
                hit_next    = 1'b1;
                rd_ptr_next = rd_ptr_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            done_reg   <= done_next;
            hit_reg    <= hit_next;
        end
    end

    // Event memory with a registered read port at the read pointer.
    always_ff @(posedge clk) begin
        if (do_write) begin
            event_store_reg[wr_ptr_reg] <= cmd.evt;
        end
        rd_data_reg <= event_store_reg[rd_ptr_reg];
    end

    // An empty pop reports all fields as zero.
    assign done        = done_reg;
    assign event_valid = done_reg && hit_reg;
    assign evt         = hit_reg ? rd_data_reg : '0;

endmodule

FILE: verif/ps2_event_checker.sv
// Watches the request and result channels of the scancode decoder, keeps its own
// copy of the keyboard state and event queue, and checks every popped event.
module ps2_event_checker
    import psd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    input  logic       done,
    input  logic       event_valid,
    input  logic [6:0] key_code,
    input  logic [6:0] char_code,
    input  logic       is_press,
    input  logic       shift_held,
    input  logic       ctrl_held,
    input  logic       alt_held,
    input  logic       extended_prefix,
    output int         failures,
    output int         outstanding
);

    localparam int CHAR_TABLE_SIZE = 58;

    // One pop answer: the valid flag and the event fields.
    typedef struct packed {
        logic   valid;
        event_t evt;
    } pop_answer_t;

    logic [6:0]  plain_chars   [CHAR_TABLE_SIZE];
    logic [6:0]  shifted_chars [CHAR_TABLE_SIZE];

    event_t      queued_events [$];
    pop_answer_t expected_pops [$];

    logic        shift_on;
    logic        ctrl_on;
    logic        alt_on;
    logic        caps_on;
    logic        prefix_seen;

    // Set-1 key code to ASCII, without and with shift.
    initial
    begin
        plain_chars = '{
            7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
            7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
            7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
            7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
            7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
        };
        shifted_chars = '{
            7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
            7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
            7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
            7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
            7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
        };
    end

    // Translate a pressed key; caps lock flips the case of letters only.
    function automatic logic [6:0] key_ascii(input logic [6:0] code, input logic shift,
                                             input logic caps);
        logic [6:0] c;
        logic       upper;
        upper = shift ^ caps;
        if (code >= CHAR_TABLE_SIZE) begin
            return 7'h00;
        end
        c = shift ? shifted_chars[code] : plain_chars[code];
        if (c >= LOWER_A && c <= LOWER_Z) begin
            if (upper) begin
                c = c - CASE_GAP;
            end
        end else if (c >= UPPER_A && c <= UPPER_Z) begin
            if (!upper) begin
                c = c + CASE_GAP;
            end
        end
        return c;
    endfunction

    // Update the keyboard state for one byte and queue its event if there is room.
    task automatic take_keyboard_byte(input logic [7:0] b);
        logic       press;
        logic [6:0] code;
        event_t     evt;
        if (b == PREFIX_BYTE) begin
            prefix_seen = 1'b1;
            return;
        end
        press = ~b[RELEASE_BIT];
        code  = b[6:0];
        if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_on = press;
        end else if (code == KEY_CTRL) begin
            ctrl_on = press;
        end else if (code == KEY_ALT) begin
            alt_on = press;
        end else if (code == KEY_CAPS && press) begin
            caps_on = ~caps_on;
        end
        evt.key_code        = code;
        evt.char_code       = press ? key_ascii(code, shift_on, caps_on) : 7'h00;
        evt.is_press        = press;
        evt.shift_held      = shift_on;
        evt.ctrl_held       = ctrl_on;
        evt.alt_held        = alt_on;
        evt.extended_prefix = prefix_seen;
        // A full queue drops the event while the modifier state still moves.
        if (queued_events.size() < QUEUE_DEPTH - 1) begin
            queued_events.push_back(evt);
        end
        prefix_seen = 1'b0;
    endtask

    // Work out the answer to a pop request.
    task automatic take_pop();
        pop_answer_t answer;
        answer = '0;
        if (queued_events.size() != 0) begin
            answer.valid = 1'b1;
            answer.evt   = queued_events.pop_front();
        end
        expected_pops.push_back(answer);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // Compare one strobed result against the oldest expected answer.
    task automatic check_pop_result();
        pop_answer_t want;
        if (expected_pops.size() == 0) begin
            $error("result strobe with no pop request waiting");
            failures++;
            return;
        end
        want = expected_pops.pop_front();
        compare_field("event_valid", want.valid, event_valid);
        compare_field("key_code", want.evt.key_code, key_code);
        compare_field("char_code", want.evt.char_code, char_code);
        compare_field("is_press", want.evt.is_press, is_press);
        compare_field("shift_held", want.evt.shift_held, shift_held);
        compare_field("ctrl_held", want.evt.ctrl_held, ctrl_held);
        compare_field("alt_held", want.evt.alt_held, alt_held);
        compare_field("extended_prefix", want.evt.extended_prefix, extended_prefix);
    endtask

    // Results are checked before a request taken at the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            queued_events.delete();
            expected_pops.delete();
            shift_on    = 1'b0;
            ctrl_on     = 1'b0;
            alt_on      = 1'b0;
            caps_on     = 1'b0;
            prefix_seen = 1'b0;
            failures    = 0;
            outstanding = 0;
        end else begin
            if (done) begin
                check_pop_result();
            end
            if (start && !busy) begin
                if (opcode == OP_POP) begin
                    take_pop();
                end else begin
                    take_keyboard_byte(rx_byte);
                end
            end
            outstanding = expected_pops.size();
        end
    end

endmodule

FILE: verif/tb_ps2_scancode_decoder_event_fifo_unit.sv
module tb_ps2_scancode_decoder_event_fifo_unit;
    import psd_pkg::*;

    localparam int QUEUE_DEPTH     = 32;
    localparam int REQUEST_TARGET  = 1400;
    localparam int PHASE_COUNT     = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       opcode;
    logic [7:0] rx_byte;
    logic       done;
    logic       event_valid;
    logic [6:0] key_code;
    logic [6:0] char_code;
    logic       is_press;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       extended_prefix;

    int         failures;
    int         outstanding;
    int         cycle_count = 0;
    int         sent_requests = 0;
    int         idle_percent = 0;

    ps2_scancode_decoder_event_fifo_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .rx_byte(rx_byte),
        .done(done),
        .event_valid(event_valid),
        .key_code(key_code),
        .char_code(char_code),
        .is_press(is_press),
        .shift_held(shift_held),
        .ctrl_held(ctrl_held),
        .alt_held(alt_held),
        .extended_prefix(extended_prefix)
    );

    ps2_event_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .rx_byte(rx_byte),
        .done(done),
        .event_valid(event_valid),
        .key_code(key_code),
        .char_code(char_code),
        .is_press(is_press),
        .shift_held(shift_held),
        .ctrl_held(ctrl_held),
        .alt_held(alt_held),
        .extended_prefix(extended_prefix),
        .failures(failures),
        .outstanding(outstanding)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one request from a falling edge and hold it until it is taken.
    // Random idle cycles come first, at the rate of the current phase.
    task automatic issue(input opcode_t op, input logic [7:0] b);
        while ($urandom_range(99) < idle_percent) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        opcode  <= op;
        rx_byte <= b;
        do begin
            @(posedge clk);
        end while (busy);
        @(negedge clk);
        sent_requests++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        issue(OP_BYTE, b);
    endtask

    task automatic send_pop();
        issue(OP_POP, 8'($urandom_range(255)));
    endtask

    // Hold the sender off until every pop request has been answered.
    task automatic drain_answers();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) begin
            @(negedge clk);
        end
    endtask

    // Mostly typing traffic: modifiers, prefixed keys, mapped keys, pops and some noise.
    task automatic random_request();
        int         pick;
        logic [7:0] modifier;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_pop();
        end else if (pick < 48) begin
            send_byte(PREFIX_BYTE);
        end else if (pick < 63) begin
            case ($urandom_range(4))
                0:       modifier = {1'b0, KEY_LSHIFT};
                1:       modifier = {1'b0, KEY_RSHIFT};
                2:       modifier = {1'b0, KEY_CTRL};
                3:       modifier = {1'b0, KEY_ALT};
                default: modifier = {1'b0, KEY_CAPS};
            endcase
            modifier[RELEASE_BIT] = 1'($urandom_range(1));
            send_byte(modifier);
        end else if (pick < 88) begin
            send_byte({1'($urandom_range(1)), 7'($urandom_range(57))});
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // Overfill the event queue, then pop it past empty.
    task automatic fill_and_drain();
        for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
            send_byte({1'($urandom_range(1)), 7'($urandom_range(127))});
        end
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
            send_pop();
        end
    endtask

    // Reset, a directed sequence, then random phases with different idle rates.
    initial
    begin
        logic [7:0] directed_bytes [20];
        directed_bytes = '{
            8'h00, 8'h1E, 8'h2A, 8'h02, 8'h3A, 8'h1E, 8'hAA, 8'h9E, 8'hBA, 8'h3A,
            8'hE0, 8'hE0, 8'h1D, 8'h38, 8'h7F, 8'hFF, 8'h80, 8'h39, 8'h36, 8'hB6
        };

        rst_n   = 1'b0;
        start   = 1'b0;
        opcode  = OP_BYTE;
        rx_byte = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pop on an empty queue, then letters, shift, caps lock, prefixes and
        // unmapped codes, and a couple of pops straight after them.
        send_pop();
        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end
        send_pop();
        send_pop();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       idle_percent = 0;
                1:       idle_percent = 52;
                2:       idle_percent = 34;
                default: idle_percent = 0;
            endcase
            while (sent_requests < (phase + 1) * REQUEST_TARGET / PHASE_COUNT) begin
                if ($urandom_range(59) == 0) begin
                    fill_and_drain();
                end else begin
                    random_request();
                end
            end
            if (phase == 1) begin
                drain_answers();
            end
        end

        // Wait for the last answers and let the pipeline settle.
        drain_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
